@@ sv/srg_pkg.sv @@
// Package with constants, types and helper functions of the subtractive random generator.
`timescale 1ns / 1ps

package srg_pkg;

  // Field widths.
  localparam int ValueW = 30;
  localparam int BoundW = 31;
  localparam int SeedW  = 31;
  localparam int PosW   = 6;

  // Scheme constants.
  localparam logic [ValueW-1:0] Modulus     = 30'd1000000000;
  localparam logic [SeedW-1:0]  BaseSeed    = 31'd131803398;
  localparam int                TableLen    = 55;
  localparam logic [PosW-1:0]   TableLast   = 6'd55;
  localparam logic [PosW-1:0]   Stride      = 6'd21;
  localparam logic [PosW-1:0]   SecondStart = 6'd31;
  localparam logic [PosW-1:0]   LagSplit    = 6'd24;
  localparam logic [1:0]        LastPass    = 2'd3;

  // Quotient by 10^9: floor(2^61 / 10^9) applied to the top 31 product bits, shifted
  // right by 31. The estimate falls short by at most two, so the remainder stays
  // below three times the modulus.
  localparam int                RecipW      = 32;
  localparam int                RecipShift  = 31;
  localparam int                RemW        = 32;
  localparam logic [RecipW-1:0] Recip       = 32'd2305843009;
  localparam logic [RemW-1:0]   RemLimit    = 32'd3000000000;

  // Command codes.
  localparam logic CmdDraw    = 1'b0;
  localparam logic CmdRestart = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SEED,
    S_SCATTER,
    S_MIX,
    S_DRAIN,
    S_RD,
    S_WB,
    S_MUL,
    S_EST,
    S_DIV,
    S_DONE
  } srg_state_t;

  // Difference of two residues, modulo 10^9.
  function automatic logic [ValueW-1:0] sub_mod(input logic [ValueW-1:0] a,
                                                input logic [ValueW-1:0] b);
    logic [ValueW:0] wide;
    wide = {1'b0, a} + {1'b0, Modulus} - {1'b0, b};
    if (a >= b) begin
      sub_mod = a - b;
    end else begin
      sub_mod = wide[ValueW-1:0];
    end
  endfunction

  // Step a table position forward, wrapping from 55 back to 1.
  function automatic logic [PosW-1:0] advance(input logic [PosW-1:0] pos);
    logic [PosW:0] nxt;
    nxt = {1'b0, pos} + 7'd1;
    if (nxt > {1'b0, TableLast}) begin
      advance = 6'd1;
    end else begin
      advance = nxt[PosW-1:0];
    end
  endfunction

endpackage

@@ sv/srg_req_if.sv @@
// Request channel interface carrying the command and bound of one item.
`timescale 1ns / 1ps

interface srg_req_if import srg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BoundW-1:0] bound;

  modport source (output valid, output cmd, output bound, input ready);
  modport sink (input valid, input cmd, input bound, output ready);
endinterface

@@ sv/srg_rsp_if.sv @@
// Response channel interface carrying the drawn value and its scaled index.
`timescale 1ns / 1ps

interface srg_rsp_if import srg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic [BoundW-1:0] index;

  modport source (output valid, output value, output index, input ready);
  modport sink (input valid, input value, input index, output ready);
endinterface

@@ sv/subtractive_random_generator.sv @@
// Top level of the subtractive random generator: table memory, seeding sequencer and draw path.
`timescale 1ns / 1ps

// Lagged subtractive generator with a 55-entry table of residues modulo 10^9 held in a
// two-read, one-write synchronous memory. A draw transfer runs from acceptance until the
// request side is ready again through a memory read, a write-back, a multiply of bound
// by value, a reciprocal multiply that estimates the quotient by 10^9, a step for the
// remainder, and a step that corrects the estimate and loads the output register. That
// last step repeats while the previous result is still held. A restart transfer folds
// the seed, then makes 55 scatter writes and 220 mixing steps (one per cycle, read two
// entries and write one) plus a final write-back. After reset the block runs this same
// seeding with seed 0 before it raises ready; seed writes are taken at any time and
// apply at the next restart. A finished result waits in the output register without
// blocking the acceptance of the next request.
module subtractive_random_generator import srg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [SeedW-1:0] cfg_wr_data,
  srg_req_if.sink          req,
  srg_rsp_if.source        rsp
);

  // Table memory.
  logic [ValueW-1:0] mem [TableLen];
  logic [ValueW-1:0] rd_a;
  logic [ValueW-1:0] rd_b;

  // Control registers.
  srg_state_t      state;
  srg_state_t      state_next;
  logic [SeedW-1:0] seed;
  logic [PosW-1:0] first_pos;
  logic [PosW-1:0] second_pos;
  logic            wr_pend;
  logic            out_valid;

  // Datapath registers.
  logic [BoundW-1:0] bound_reg;
  logic [SeedW-1:0]  c0;
  logic [ValueW-1:0] c1;
  logic [PosW-1:0]   pos_j;
  logic [PosW-1:0]   cnt;
  logic [1:0]        pass;
  logic [PosW-1:0]   wr_addr;
  logic [ValueW-1:0] v_reg;
  logic [BoundW+ValueW-1:0] prod_reg;
  logic [RemW-1:0]   rem;
  logic [BoundW-1:0] quo;
  logic [ValueW-1:0] out_value;
  logic [BoundW-1:0] out_index;

  // Combinational signals.
  logic                  mem_we;
  logic [PosW-1:0]       mem_waddr;
  logic [ValueW-1:0]     mem_wdata;
  logic [PosW-1:0]       ra;
  logic [PosW-1:0]       rb;
  logic [ValueW-1:0]     diff;
  logic [SeedW-1:0]      abs_seed;
  logic [SeedW-1:0]      c0_sub1;
  logic [SeedW-1:0]      c0_sub2;
  logic [ValueW-1:0]     c0_mod;
  logic [PosW:0]         scat_sum;
  logic [PosW-1:0]       scat_step;
  logic [PosW-1:0]       mix_b;
  logic [BoundW+ValueW-1:0] product;
  logic [BoundW+RecipW-1:0] est_full;
  logic [BoundW+ValueW-1:0] quo_times_m;
  logic [RemW-1:0]       rem_next;
  logic [BoundW-1:0]     quo_fixed;
  logic [BoundW-1:0]     idx_clamped;
  logic                  out_load;
  logic                  req_fire;

  assign req_fire = req.valid && req.ready;
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  // Shared subtract unit for draws and mixing steps.
  assign diff = sub_mod(rd_a, rd_b);

  // Seed folding: magnitude of the distance to the base seed, reduced modulo 10^9.
  assign abs_seed = (seed > BaseSeed) ? (seed - BaseSeed) : (BaseSeed - seed);
  assign c0_sub1  = c0 - {1'b0, Modulus};
  assign c0_sub2  = c0 - {Modulus, 1'b0};
  always_comb begin
    if (c0 >= {Modulus, 1'b0}) begin
      c0_mod = c0_sub2[ValueW-1:0];
    end else if (c0 >= {1'b0, Modulus}) begin
      c0_mod = c0_sub1[ValueW-1:0];
    end else begin
      c0_mod = c0[ValueW-1:0];
    end
  end

  // Scatter position steps by the stride, wrapping over the table length.
  assign scat_sum  = {1'b0, pos_j} + {1'b0, Stride};
  assign scat_step = (scat_sum > {1'b0, TableLast}) ? (scat_sum[PosW-1:0] - TableLast)
                                                    : scat_sum[PosW-1:0];

  // Zero-based address of the mixing partner entry, 31 positions ahead.
  assign mix_b = (pos_j <= LagSplit) ? (pos_j + 6'd30) : (pos_j - 6'd25);

  // Scaled index product, then its quotient by 10^9: a reciprocal estimate that falls
  // short by at most two, and the remainder that tells how far.
  assign product     = bound_reg * v_reg;
  assign est_full    = prod_reg[BoundW+ValueW-1:ValueW] * Recip;
  assign quo_times_m = quo * Modulus;
  assign rem_next    = prod_reg[RemW-1:0] - quo_times_m[RemW-1:0];

  // Raise the estimate by the number of whole moduli left in the remainder.
  always_comb begin
    if (rem >= {1'b0, Modulus, 1'b0}) begin
      quo_fixed = quo + 31'd2;
    end else if (rem >= {2'b00, Modulus}) begin
      quo_fixed = quo + 31'd1;
    end else begin
      quo_fixed = quo;
    end
  end

  // Clamp the quotient below the bound; a zero bound gives zero.
  always_comb begin
    if (bound_reg == '0) begin
      idx_clamped = '0;
    end else if (quo_fixed >= bound_reg) begin
      idx_clamped = bound_reg - 31'd1;
    end else begin
      idx_clamped = quo_fixed;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.cmd == CmdRestart) ? S_PREP : S_RD;
        end
      end
      S_PREP:    state_next = S_SEED;
      S_SEED:    state_next = S_SCATTER;
      S_SCATTER: begin
        if (cnt == TableLast - 6'd1) begin
          state_next = S_MIX;
        end
      end
      S_MIX: begin
        if ((pos_j == TableLast) && (pass == LastPass)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:   state_next = S_IDLE;
      S_RD:      state_next = S_WB;
      S_WB:      state_next = S_MUL;
      S_MUL:     state_next = S_EST;
      S_EST:     state_next = S_DIV;
      S_DIV:     state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory port control and request ready.
  always_comb begin
    req.ready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = diff;
    ra        = first_pos - 6'd1;
    rb        = second_pos - 6'd1;
    unique case (state)
      S_IDLE: req.ready = 1'b1;
      S_SEED: begin
        mem_we    = 1'b1;
        mem_waddr = TableLast - 6'd1;
        mem_wdata = c0_mod;
      end
      S_SCATTER: begin
        mem_we    = 1'b1;
        mem_waddr = pos_j - 6'd1;
        mem_wdata = c1;
      end
      S_MIX: begin
        ra        = pos_j - 6'd1;
        rb        = mix_b;
        mem_we    = wr_pend;
        mem_waddr = wr_addr;
      end
      S_DRAIN: begin
        mem_we    = wr_pend;
        mem_waddr = wr_addr;
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = first_pos - 6'd1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Table memory with registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // Control state; reset starts a restart with seed zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_PREP;
      seed       <= '0;
      first_pos  <= '0;
      second_pos <= SecondStart;
      wr_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      wr_pend <= (state == S_MIX);
      if (cfg_wr_en) begin
        seed <= cfg_wr_data;
      end
      if (req_fire && (req.cmd == CmdDraw)) begin
        first_pos  <= advance(first_pos);
        second_pos <= advance(second_pos);
      end
      if (state == S_DRAIN) begin
        first_pos  <= '0;
        second_pos <= SecondStart;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      bound_reg <= req.bound;
    end
    if (out_load) begin
      out_value <= v_reg;
      out_index <= idx_clamped;
    end
    wr_addr <= pos_j - 6'd1;
    case (state)
      S_PREP: c0 <= abs_seed;
      S_SEED: begin
        c0    <= {1'b0, c0_mod};
        c1    <= 30'd1;
        pos_j <= Stride;
        cnt   <= 6'd1;
      end
      S_SCATTER: begin
        c1    <= sub_mod(c0[ValueW-1:0], c1);
        c0    <= {1'b0, c1};
        pos_j <= scat_step;
        cnt   <= cnt + 6'd1;
        if (cnt == TableLast - 6'd1) begin
          pos_j <= 6'd1;
          pass  <= '0;
        end
      end
      S_MIX: begin
        if (pos_j == TableLast) begin
          pos_j <= 6'd1;
          pass  <= pass + 2'd1;
        end else begin
          pos_j <= pos_j + 6'd1;
        end
      end
      S_WB:  v_reg <= diff;
      S_MUL: prod_reg <= product;
      S_EST: quo <= est_full[BoundW+RecipShift-1:RecipShift];
      S_DIV: rem <= rem_next;
      default: begin
        c0 <= c0;
      end
    endcase
  end

  assign rsp.valid = out_valid;
  assign rsp.value = out_value;
  assign rsp.index = out_index;

  // A mixing write-back never targets an entry being read in the same cycle.
  a_mix_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX && wr_pend) |-> (wr_addr != ra && wr_addr != rb))
    else $error("mixing write-back collides with a read");

  // Writes stay inside the table.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mem_waddr < TableLast))
    else $error("table write address out of range");

  // Once stepped, the second position leads the first by 31 modulo the table length.
  a_lag_kept: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && first_pos != '0) |->
      ({1'b0, second_pos} == {1'b0, first_pos} + 7'd31 ||
       {1'b0, second_pos} + 7'd24 == {1'b0, first_pos}))
    else $error("lagged positions out of step");

  // The quotient estimate leaves less than three moduli in the remainder.
  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (rem < RemLimit))
    else $error("division remainder out of range");

  // A finished draw waits while the held result is not taken.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !rsp.ready) |=> (state == S_DONE))
    else $error("finished draw left while output was full");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the subtractive random generator with its own predictor.
`timescale 1ns / 1ps

module tb_top import srg_pkg::*; ();

  // Predictor constants and run limits.
  localparam int unsigned ModVal        = Modulus;
  localparam int unsigned BaseVal       = BaseSeed;
  localparam int unsigned StrideVal     = Stride;
  localparam int unsigned SecondVal     = SecondStart;
  localparam int unsigned TableVal      = TableLen;
  localparam int unsigned MixLag        = 30;
  localparam int unsigned MixPasses     = 4;
  localparam int          MaxIdle       = 6;
  localparam int          RestartCycles = 300;
  localparam int          IdleLimit     = 4000;
  localparam int          PhaseItems    = 145;

  // One expected draw result.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [BoundW-1:0] index;
  } draw_t;

  // Shadow of the generator table plus the queue of draws still owed by the block.
  class draw_scoreboard;
    logic [SeedW-1:0]  seed_reg;
    int unsigned       lag_tbl [1:TableLen];
    int unsigned       first_pos;
    int unsigned       second_pos;
    draw_t             pending_draws[$];
    int                mismatches;

    function new();
      seed_reg = '0;
      mismatches = 0;
      rebuild_table();
    endfunction

    function int unsigned residue_diff(int unsigned a, int unsigned b);
      return (a >= b) ? a - b : a + ModVal - b;
    endfunction

    function int unsigned next_pos(int unsigned p);
      return (p >= TableVal) ? 1 : p + 1;
    endfunction

    // Seeding: scatter the start values at stride 21, then mix the table four times.
    function void rebuild_table();
      int unsigned s;
      int unsigned c0;
      int unsigned c1;
      int unsigned j;
      int unsigned k;
      s = {1'b0, seed_reg};
      c0 = ((s > BaseVal) ? s - BaseVal : BaseVal - s) % ModVal;
      lag_tbl[TableLen] = c0;
      c1 = 1;
      for (int unsigned i = 1; i < TableVal; i++) begin
        j = (StrideVal * i) % TableVal;
        lag_tbl[j] = c1;
        c1 = residue_diff(c0, c1);
        c0 = lag_tbl[j];
      end
      for (int unsigned p = 0; p < MixPasses; p++) begin
        for (int unsigned m = 1; m <= TableVal; m++) begin
          k = 1 + (m + MixLag) % TableVal;
          lag_tbl[m] = residue_diff(lag_tbl[m], lag_tbl[k]);
        end
      end
      first_pos = 0;
      second_pos = SecondVal;
    endfunction

    function void note_seed(logic [SeedW-1:0] s);
      seed_reg = s;
    endfunction

    // An accepted request either reseeds the table or owes one draw result.
    function void note_transfer(logic op, logic [BoundW-1:0] bound);
      draw_t            owed;
      int unsigned      v;
      longint unsigned  scaled;
      if (op == CmdRestart) begin
        rebuild_table();
      end else begin
        first_pos = next_pos(first_pos);
        second_pos = next_pos(second_pos);
        v = residue_diff(lag_tbl[first_pos], lag_tbl[second_pos]);
        lag_tbl[first_pos] = v;
        if (bound == '0) begin
          scaled = 0;
        end else begin
          scaled = (64'(bound) * 64'(v)) / 64'(ModVal);
          if (scaled >= 64'(bound)) begin
            scaled = 64'(bound) - 64'd1;
          end
        end
        owed.value = ValueW'(v);
        owed.index = scaled[BoundW-1:0];
        pending_draws.push_back(owed);
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare one accepted result, field by field, with the oldest owed draw.
    task check_result(logic [ValueW-1:0] value, logic [BoundW-1:0] index);
      draw_t owed;
      if (pending_draws.size() == 0) begin
        report($sformatf("result with no draw owed: value=%0d index=%0d", value, index));
      end else begin
        owed = pending_draws.pop_front();
        if (value !== owed.value) begin
          report($sformatf("value got %0d want %0d", value, owed.value));
        end
        if (index !== owed.index) begin
          report($sformatf("index got %0d want %0d", index, owed.index));
        end
      end
    endtask

    function int outstanding();
      return pending_draws.size();
    endfunction

    task flag_leftovers();
      draw_t owed;
      while (pending_draws.size() > 0) begin
        owed = pending_draws.pop_front();
        report($sformatf("draw never returned: value=%0d index=%0d", owed.value, owed.index));
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [SeedW-1:0] cfg_wr_data;
  bit               send_calm;
  bit               recv_calm;
  draw_scoreboard   board;

  srg_req_if req ();
  srg_rsp_if rsp ();

  subtractive_random_generator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bounds weighted toward zero, tiny values, the top, powers of two and the modulus.
  function automatic logic [BoundW-1:0] pick_bound();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return BoundW'($urandom_range(1, 16));
      2: return {BoundW{1'b1}};
      3: return BoundW'($urandom_range(999999990, 1000000010));
      4: return BoundW'(1) << $urandom_range(0, BoundW - 1);
      default: return BoundW'($urandom());
    endcase
  endfunction

  // Present one request and hold it until the transfer; valid stays high afterward.
  task automatic send_item(input logic op, input logic [BoundW-1:0] bound);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= op;
    req.bound <= bound;
    do @(posedge clk); while (req.ready !== 1'b1);
    board.note_transfer(op, bound);
  endtask

  // Stop sending and wait until every owed draw has come back.
  task automatic drain_results();
    req.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // Seed writes happen only with the block idle: drain, then wait out a restart that may still be running.
  task automatic load_seed(input logic [SeedW-1:0] s);
    drain_results();
    repeat (RestartCycles) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.note_seed(s);
  endtask

  // Mostly draws with occasional restarts, idle-mode flips and full drains.
  task automatic random_run(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
      if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
      if ($urandom_range(0, 199) == 0) drain_results();
      if ($urandom_range(0, 79) == 0) begin
        send_item(CmdRestart, pick_bound());
      end else begin
        send_item(CmdDraw, pick_bound());
      end
    end
  endtask

  // Result side: random stalls, then take and check each transfer.
  initial begin : result_sink
    int unsigned stall;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, MaxIdle);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      board.check_result(rsp.value, rsp.index);
    end
  end

  // Watchdog: too long without any transfer ends the run.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if (rst === 1'b1 || (req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence: reset, directed items, then seeded phases of random items.
  initial begin : stimulus
    logic [SeedW-1:0] seeds [0:8];
    board = new();
    send_calm = 1'b0;
    recv_calm = 1'b0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    req.valid <= 1'b0;
    req.cmd <= CmdDraw;
    req.bound <= '0;
    seeds = '{31'h7FFFFFFF, BaseSeed, BaseSeed + 31'd1, BaseSeed - 31'd1, 31'd1131803398,
              31'd0, 31'd0, 31'd1, 31'd0};
    seeds[6] = SeedW'($urandom());
    seeds[8] = SeedW'($urandom_range(0, 999));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed draws from the reset table, then restarts with the reset seed and more draws.
    send_item(CmdDraw, '0);
    send_item(CmdDraw, 31'd1);
    send_item(CmdDraw, {BoundW{1'b1}});
    send_item(CmdDraw, 31'd1000000000);
    send_item(CmdDraw, 31'd999999999);
    send_item(CmdDraw, 31'd1000000001);
    send_item(CmdDraw, 31'h40000000);
    send_item(CmdDraw, 31'h2AAAAAAA);
    send_item(CmdDraw, 31'h55555555);
    send_item(CmdDraw, 31'd2);
    send_item(CmdRestart, {BoundW{1'b1}});
    send_item(CmdDraw, {BoundW{1'b1}});
    send_item(CmdDraw, '0);
    send_item(CmdRestart, '0);
    send_item(CmdDraw, 31'd1000000000);

    // Each phase loads a seed, restarts, and runs random traffic.
    for (int ph = 0; ph < 9; ph++) begin
      send_calm = (ph == 2);
      recv_calm = (ph == 4);
      load_seed(seeds[ph]);
      send_item(CmdRestart, pick_bound());
      random_run(PhaseItems);
    end

    drain_results();
    repeat (RestartCycles) @(posedge clk);
    board.flag_leftovers();
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
